/* hdl/twc_pkg.sv */
`default_nettype none
package twc_pkg;

  localparam int TIME_FRAC_BITS = 16;
  localparam int AMP_FRAC_BITS  = 4;
  localparam int AMP_WIDTH      = 16;
  localparam int NET_W          = AMP_WIDTH + 1;
  localparam int TIME_W         = 32;
  localparam int COEF_W         = 20;
  localparam int PACK_W         = 3 * COEF_W;
  localparam int MIN_W          = 16;
  localparam int INDEX_W        = 4;

  localparam logic [AMP_WIDTH-1:0] PED_A = AMP_WIDTH'(60 << AMP_FRAC_BITS);
  localparam logic [AMP_WIDTH-1:0] PED_B = AMP_WIDTH'(50 << AMP_FRAC_BITS);
  localparam logic [AMP_WIDTH-1:0] PED_C = AMP_WIDTH'(60 << AMP_FRAC_BITS);

  localparam logic [TIME_W-1:0] CABLE_RESET =
    TIME_W'(((64'd573 << TIME_FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [MIN_W-1:0] MIN_AMP_RESET = MIN_W'(800);

  // root widths of the two square roots and the quotient width of the reciprocal
  localparam int SQ_ROOT_W = (2 * TIME_FRAC_BITS - AMP_FRAC_BITS + AMP_WIDTH) / 2;
  localparam int DIV_Q_W   = 2 * TIME_FRAC_BITS + AMP_FRAC_BITS + 1;
  localparam int RS_ROOT_W = (DIV_Q_W + 1) / 2;
  localparam int LANE_LAT  = SQ_ROOT_W + DIV_Q_W + RS_ROOT_W + 2;

  localparam int WALK_W = 40;
  localparam int BASE_W = TIME_W + 3;
  localparam int ACC_W  = 44;

  localparam logic [INDEX_W-1:0] REG_WALK_SQRT_CH2  = 4'd0;
  localparam logic [INDEX_W-1:0] REG_WALK_SQRT_CH3  = 4'd1;
  localparam logic [INDEX_W-1:0] REG_WALK_SQRT_CH4  = 4'd2;
  localparam logic [INDEX_W-1:0] REG_WALK_RSQRT_CH2 = 4'd3;
  localparam logic [INDEX_W-1:0] REG_WALK_RSQRT_CH3 = 4'd4;
  localparam logic [INDEX_W-1:0] REG_WALK_RSQRT_CH4 = 4'd5;
  localparam logic [INDEX_W-1:0] REG_CABLE_OFFSET   = 4'd6;
  localparam logic [INDEX_W-1:0] REG_MIN_NET_AMP    = 4'd7;

  typedef struct packed {
    logic                     ok;
    logic                     win;
    logic signed [NET_W-1:0]  na;
    logic signed [NET_W-1:0]  nb;
    logic signed [NET_W-1:0]  nc;
    logic signed [BASE_W-1:0] base;
  } side_t;

endpackage
`default_nettype wire

/* hdl/twc_if.sv */
`default_nettype none
interface twc_in_if;
  logic                                valid;
  logic                                ready;
  logic        [twc_pkg::AMP_WIDTH-1:0] amp_a;
  logic        [twc_pkg::AMP_WIDTH-1:0] amp_b;
  logic        [twc_pkg::AMP_WIDTH-1:0] amp_c;
  logic signed [twc_pkg::TIME_W-1:0]    time_a;
  logic signed [twc_pkg::TIME_W-1:0]    time_b;
  logic signed [twc_pkg::TIME_W-1:0]    time_c;
  modport source (output valid, amp_a, amp_b, amp_c, time_a, time_b, time_c, input ready);
  modport sink (input valid, amp_a, amp_b, amp_c, time_a, time_b, time_c, output ready);
endinterface

interface twc_out_if;
  logic                              valid;
  logic                              ready;
  logic                              event_ok;
  logic                              in_window;
  logic signed [twc_pkg::TIME_W-1:0] tof_corrected;
  logic signed [twc_pkg::NET_W-1:0]  net_amp_a;
  logic signed [twc_pkg::NET_W-1:0]  net_amp_b;
  logic signed [twc_pkg::NET_W-1:0]  net_amp_c;
  modport source (output valid, event_ok, in_window, tof_corrected, net_amp_a, net_amp_b,
                  net_amp_c, input ready);
  modport sink (input valid, event_ok, in_window, tof_corrected, net_amp_a, net_amp_b,
                net_amp_c, output ready);
endinterface

interface twc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [twc_pkg::INDEX_W-1:0]        index;
  logic [twc_pkg::PACK_W-1:0]         data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* hdl/twc_sqrt_cell.sv */
`default_nettype none
module twc_sqrt_cell #(
  parameter int ROOT_W = twc_pkg::SQ_ROOT_W,
  parameter int TAG_W  = twc_pkg::AMP_WIDTH
) (
  input  wire logic                clk,
  input  wire logic                ce,
  input  wire logic [2*ROOT_W-1:0] rad_i,
  input  wire logic [ROOT_W:0]     rem_i,
  input  wire logic [ROOT_W-1:0]   root_i,
  input  wire logic [TAG_W-1:0]    tag_i,
  output logic      [2*ROOT_W-1:0] rad,
  output logic      [ROOT_W:0]     rem,
  output logic      [ROOT_W-1:0]   root,
  output logic      [TAG_W-1:0]    tag
);
  logic [ROOT_W+2:0] rem_t;
  logic [ROOT_W+2:0] trial;
  logic [ROOT_W+2:0] diff;
  logic              fit;

  always_comb begin
    rem_t = {rem_i, rad_i[2*ROOT_W-1 -: 2]};
    trial = {1'b0, root_i, 2'b01};
    fit   = rem_t >= trial;
    diff  = rem_t - trial;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      rad  <= {rad_i[2*ROOT_W-3:0], 2'b00};
      rem  <= fit ? diff[ROOT_W:0] : rem_t[ROOT_W:0];
      root <= {root_i[ROOT_W-2:0], fit};
      tag  <= tag_i;
    end
  end
endmodule
`default_nettype wire

/* hdl/twc_div_cell.sv */
`default_nettype none
module twc_div_cell #(
  parameter int Q_W   = twc_pkg::DIV_Q_W,
  parameter int DEN_W = twc_pkg::AMP_WIDTH,
  parameter int TAG_W = twc_pkg::SQ_ROOT_W
) (
  input  wire logic             clk,
  input  wire logic             ce,
  input  wire logic [Q_W-1:0]   num_i,
  input  wire logic [DEN_W-1:0] rem_i,
  input  wire logic [Q_W-1:0]   q_i,
  input  wire logic [DEN_W-1:0] den_i,
  input  wire logic [TAG_W-1:0] tag_i,
  output logic      [Q_W-1:0]   num,
  output logic      [DEN_W-1:0] rem,
  output logic      [Q_W-1:0]   q,
  output logic      [DEN_W-1:0] den,
  output logic      [TAG_W-1:0] tag
);
  logic [DEN_W:0] rem_t;
  logic [DEN_W:0] diff;
  logic           fit;

  always_comb begin
    rem_t = {rem_i, num_i[Q_W-1]};
    fit   = rem_t >= {1'b0, den_i};
    diff  = rem_t - {1'b0, den_i};
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      num <= {num_i[Q_W-2:0], 1'b0};
      rem <= fit ? diff[DEN_W-1:0] : rem_t[DEN_W-1:0];
      q   <= {q_i[Q_W-2:0], fit};
      den <= den_i;
      tag <= tag_i;
    end
  end
endmodule
`default_nettype wire

/* hdl/twc_lane.sv */
`default_nettype none
module twc_lane (
  input  wire logic                                 clk,
  input  wire logic                                 ce,
  input  wire logic        [twc_pkg::AMP_WIDTH-1:0] n,
  input  wire logic        [twc_pkg::PACK_W-1:0]    sq,
  input  wire logic        [twc_pkg::PACK_W-1:0]    rs,
  output logic signed      [twc_pkg::WALK_W-1:0]    walk
);
  localparam int AW  = twc_pkg::AMP_WIDTH;
  localparam int SW  = twc_pkg::SQ_ROOT_W;
  localparam int QW  = twc_pkg::DIV_Q_W;
  localparam int RW  = twc_pkg::RS_ROOT_W;
  localparam int CW  = twc_pkg::COEF_W;
  localparam int F   = twc_pkg::TIME_FRAC_BITS;
  localparam int AF  = twc_pkg::AMP_FRAC_BITS;
  localparam int PW  = 48;
  localparam int RTW = AW + SW;

  // square root of n scaled to Q.F
  logic [2*SW-1:0] s_rad  [0:SW];
  logic [SW:0]     s_rem  [0:SW];
  logic [SW-1:0]   s_root [0:SW];
  logic [AW-1:0]   s_tag  [0:SW];

  assign s_rad[0]  = {n, (2*SW-AW)'(0)};
  assign s_rem[0]  = '0;
  assign s_root[0] = '0;
  assign s_tag[0]  = n;

  for (genvar i = 0; i < SW; i++) begin : g_sq
    twc_sqrt_cell #(.ROOT_W(SW), .TAG_W(AW)) u_cell (
      .clk, .ce,
      .rad_i(s_rad[i]), .rem_i(s_rem[i]), .root_i(s_root[i]), .tag_i(s_tag[i]),
      .rad(s_rad[i+1]), .rem(s_rem[i+1]), .root(s_root[i+1]), .tag(s_tag[i+1])
    );
  end

  // reciprocal 2^(2F+AF) / n
  logic [QW-1:0] d_num [0:QW];
  logic [AW-1:0] d_rem [0:QW];
  logic [QW-1:0] d_q   [0:QW];
  logic [AW-1:0] d_den [0:QW];
  logic [SW-1:0] d_tag [0:QW];

  assign d_num[0] = {1'b1, (QW-1)'(0)};
  assign d_rem[0] = '0;
  assign d_q[0]   = '0;
  assign d_den[0] = s_tag[SW];
  assign d_tag[0] = s_root[SW];

  for (genvar i = 0; i < QW; i++) begin : g_div
    twc_div_cell #(.Q_W(QW), .DEN_W(AW), .TAG_W(SW)) u_cell (
      .clk, .ce,
      .num_i(d_num[i]), .rem_i(d_rem[i]), .q_i(d_q[i]), .den_i(d_den[i]), .tag_i(d_tag[i]),
      .num(d_num[i+1]), .rem(d_rem[i+1]), .q(d_q[i+1]), .den(d_den[i+1]), .tag(d_tag[i+1])
    );
  end

  // square root of the reciprocal
  logic [2*RW-1:0] r_rad  [0:RW];
  logic [RW:0]     r_rem  [0:RW];
  logic [RW-1:0]   r_root [0:RW];
  logic [RTW-1:0]  r_tag  [0:RW];

  assign r_rad[0]  = {(2*RW-QW)'(0), d_q[QW]};
  assign r_rem[0]  = '0;
  assign r_root[0] = '0;
  assign r_tag[0]  = {d_den[QW], d_tag[QW]};

  for (genvar i = 0; i < RW; i++) begin : g_rs
    twc_sqrt_cell #(.ROOT_W(RW), .TAG_W(RTW)) u_cell (
      .clk, .ce,
      .rad_i(r_rad[i]), .rem_i(r_rem[i]), .root_i(r_root[i]), .tag_i(r_tag[i]),
      .rad(r_rad[i+1]), .rem(r_rem[i+1]), .root(r_root[i+1]), .tag(r_tag[i+1])
    );
  end

  logic [SW-1:0] s_fin;
  logic [RW-1:0] r_fin;
  logic [AW-1:0] n_fin;

  assign s_fin = r_tag[RW][SW-1:0];
  assign n_fin = r_tag[RW][RTW-1:SW];
  assign r_fin = r_root[RW];

  logic signed [CW+SW:0] p_bs;
  logic signed [CW+RW:0] p_br;
  logic signed [CW+AW:0] p_cn;
  logic signed [CW+AW:0] p_dn;
  logic signed [CW:0]    a_sum;

  always_ff @(posedge clk) begin
    if (ce) begin
      p_bs  <= $signed(sq[2*CW-1:CW]) * $signed({1'b0, s_fin});
      p_br  <= $signed(rs[2*CW-1:CW]) * $signed({1'b0, r_fin});
      p_cn  <= $signed(sq[3*CW-1:2*CW]) * $signed({1'b0, n_fin});
      p_dn  <= $signed(rs[3*CW-1:2*CW]) * $signed({1'b0, n_fin});
      a_sum <= (CW+1)'($signed(sq[CW-1:0])) + (CW+1)'($signed(rs[CW-1:0]));
    end
  end

  logic signed [PW-1:0] t_bs;
  logic signed [PW-1:0] t_br;
  logic signed [PW-1:0] t_cn;
  logic signed [PW-1:0] t_dn;
  logic signed [PW-1:0] w_sum;

  always_comb begin
    t_bs  = (PW'(p_bs) + (PW'(1) <<< (F-1))) >>> F;
    t_br  = (PW'(p_br) + (PW'(1) <<< (F-1))) >>> F;
    t_cn  = (PW'(p_cn) + (PW'(1) <<< (AF-1))) >>> AF;
    t_dn  = (PW'(p_dn) + (PW'(1) <<< (AF-1))) >>> AF;
    w_sum = PW'(a_sum) + t_bs + t_br + t_cn + t_dn;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      walk <= w_sum[twc_pkg::WALK_W-1:0];
    end
  end
endmodule
`default_nettype wire

/* hdl/tof_time_walk_correct_core.sv */
// channel  dir  content
// hits     in   amp_a/b/c, time_a/b/c of one event
// result   out  event_ok, in_window, tof_corrected, net_amp_a/b/c
// cfg      in   index, data; always ready
// One event per cycle while result is not stalled; results pass the front stage, the lanes,
// the combine stage and the output register. Each lane holds cell chains for square root,
// reciprocal divider and inverse square root, one bit step per cell.
// A stalled result holds the whole pipeline; hits.ready is high unless a valid result is stalled.
// rst clears valid bits and restores register reset values.
`default_nettype none
module tof_time_walk_correct_core (
  input wire logic   clk,
  input wire logic   rst,
  twc_in_if.sink     hits,
  twc_out_if.source  result,
  twc_cfg_if.sink    cfg
);
  localparam int AW  = twc_pkg::AMP_WIDTH;
  localparam int NW  = twc_pkg::NET_W;
  localparam int TW  = twc_pkg::TIME_W;
  localparam int BW  = twc_pkg::BASE_W;
  localparam int CW  = twc_pkg::ACC_W;
  localparam int LAT = twc_pkg::LANE_LAT;

  logic [twc_pkg::PACK_W-1:0] walk_sqrt_ch2, walk_sqrt_ch3, walk_sqrt_ch4;
  logic [twc_pkg::PACK_W-1:0] walk_rsqrt_ch2, walk_rsqrt_ch3, walk_rsqrt_ch4;
  logic [TW-1:0]              cable_offset;
  logic [twc_pkg::MIN_W-1:0]  min_net_amp;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_sqrt_ch2  <= '0;
      walk_sqrt_ch3  <= '0;
      walk_sqrt_ch4  <= '0;
      walk_rsqrt_ch2 <= '0;
      walk_rsqrt_ch3 <= '0;
      walk_rsqrt_ch4 <= '0;
      cable_offset   <= twc_pkg::CABLE_RESET;
      min_net_amp    <= twc_pkg::MIN_AMP_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        twc_pkg::REG_WALK_SQRT_CH2:  walk_sqrt_ch2  <= cfg.data;
        twc_pkg::REG_WALK_SQRT_CH3:  walk_sqrt_ch3  <= cfg.data;
        twc_pkg::REG_WALK_SQRT_CH4:  walk_sqrt_ch4  <= cfg.data;
        twc_pkg::REG_WALK_RSQRT_CH2: walk_rsqrt_ch2 <= cfg.data;
        twc_pkg::REG_WALK_RSQRT_CH3: walk_rsqrt_ch3 <= cfg.data;
        twc_pkg::REG_WALK_RSQRT_CH4: walk_rsqrt_ch4 <= cfg.data;
        twc_pkg::REG_CABLE_OFFSET:   cable_offset   <= cfg.data[TW-1:0];
        twc_pkg::REG_MIN_NET_AMP:    min_net_amp    <= cfg.data[twc_pkg::MIN_W-1:0];
        default: ;
      endcase
    end
  end

  logic ce;
  logic out_valid;

  assign ce         = !out_valid || result.ready;
  assign hits.ready = ce;

  // front stage
  twc_pkg::side_t side_next;
  logic [AW-1:0]  na_u, nb_u, nc_u;
  logic signed [NW-1:0] mn_s;

  always_comb begin
    mn_s = $signed({1'b0, min_net_amp});
    side_next.na = $signed({1'b0, hits.amp_a}) - $signed({1'b0, twc_pkg::PED_A});
    side_next.nb = $signed({1'b0, hits.amp_b}) - $signed({1'b0, twc_pkg::PED_B});
    side_next.nc = $signed({1'b0, hits.amp_c}) - $signed({1'b0, twc_pkg::PED_C});
    side_next.ok = (hits.time_a > 0) && (hits.time_b > 0) && (hits.time_c > 0)
                && (hits.amp_a != '0) && (hits.amp_b != '0) && (hits.amp_c != '0);
    side_next.win = side_next.ok && (side_next.na > mn_s) && (side_next.nb > mn_s)
                 && (side_next.nc > mn_s);
    side_next.base = (BW'(hits.time_a) <<< 1) - BW'(hits.time_b) - BW'(hits.time_c)
                   - (BW'($signed(cable_offset)) <<< 1);
    na_u = side_next.win ? side_next.na[AW-1:0] : AW'(1);
    nb_u = side_next.win ? side_next.nb[AW-1:0] : AW'(1);
    nc_u = side_next.win ? side_next.nc[AW-1:0] : AW'(1);
  end

  twc_pkg::side_t side;
  logic [AW-1:0]  n_a, n_b, n_c;
  logic           v_front;

  always_ff @(posedge clk) begin
    if (ce) begin
      side <= side_next;
      n_a  <= na_u;
      n_b  <= nb_u;
      n_c  <= nc_u;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_front <= 1'b0;
    end else if (ce) begin
      v_front <= hits.valid;
    end
  end

  logic signed [twc_pkg::WALK_W-1:0] w_a, w_b, w_c;

  twc_lane u_lane_a (.clk, .ce, .n(n_a), .sq(walk_sqrt_ch2), .rs(walk_rsqrt_ch2), .walk(w_a));
  twc_lane u_lane_b (.clk, .ce, .n(n_b), .sq(walk_sqrt_ch3), .rs(walk_rsqrt_ch3), .walk(w_b));
  twc_lane u_lane_c (.clk, .ce, .n(n_c), .sq(walk_sqrt_ch4), .rs(walk_rsqrt_ch4), .walk(w_c));

  // side line alongside the lanes
  twc_pkg::side_t side_line [0:LAT-1];
  logic [LAT-1:0] v_line;

  always_ff @(posedge clk) begin
    if (ce) begin
      side_line[0] <= side;
      for (int i = 1; i < LAT; i++) begin
        side_line[i] <= side_line[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_line <= '0;
    end else if (ce) begin
      v_line <= {v_line[LAT-2:0], v_front};
    end
  end

  // combine
  twc_pkg::side_t   side_c;
  logic signed [CW-1:0] acc;
  logic           v_comb;

  always_ff @(posedge clk) begin
    if (ce) begin
      side_c <= side_line[LAT-1];
      acc    <= CW'(side_line[LAT-1].base) - (CW'(w_a) <<< 1) - CW'(w_b) - CW'(w_c);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_comb <= 1'b0;
    end else if (ce) begin
      v_comb <= v_line[LAT-1];
    end
  end

  logic signed [CW-1:0] half;
  logic signed [TW-1:0] tof_next;

  always_comb begin
    half = (acc + CW'(1)) >>> 1;
    if (!side_c.win) begin
      tof_next = '0;
    end else if (half > CW'(32'sh7fffffff)) begin
      tof_next = 32'sh7fffffff;
    end else if (half < -CW'(33'sh080000000)) begin
      tof_next = 32'sh80000000;
    end else begin
      tof_next = half[TW-1:0];
    end
  end

  logic                 ok_q, win_q;
  logic signed [TW-1:0] tof_q;
  logic signed [NW-1:0] na_q, nb_q, nc_q;

  always_ff @(posedge clk) begin
    if (ce) begin
      ok_q  <= side_c.ok;
      win_q <= side_c.win;
      tof_q <= tof_next;
      na_q  <= side_c.na;
      nb_q  <= side_c.nb;
      nc_q  <= side_c.nc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= v_comb;
    end
  end

  assign result.valid         = out_valid;
  assign result.event_ok      = ok_q;
  assign result.in_window     = win_q;
  assign result.tof_corrected = tof_q;
  assign result.net_amp_a     = na_q;
  assign result.net_amp_b     = nb_q;
  assign result.net_amp_c     = nc_q;

  a_zero_outside: assert property (@(posedge clk) disable iff (rst)
    out_valid && !win_q |-> tof_q == '0) else $error("tof not zero outside window");
  a_win_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && win_q |-> ok_q) else $error("window without ok");
  a_win_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && win_q |-> !na_q[NW-1] && !nb_q[NW-1] && !nc_q[NW-1])
    else $error("negative net amplitude in window");
  a_no_take_stalled: assert property (@(posedge clk) disable iff (rst)
    hits.valid && hits.ready |-> !(out_valid && !result.ready))
    else $error("transaction taken while result stalled");
endmodule
`default_nettype wire
